[src/button_hold_qualifier_defines.svh]
// Assertion macros for the button hold qualifier
`ifndef BUTTON_HOLD_QUALIFIER_DEFINES_SVH
`define BUTTON_HOLD_QUALIFIER_DEFINES_SVH

`ifndef SYNTHESIS
`define BHQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bhq same-cycle check failed");
`define BHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bhq next-cycle check failed");
`else
`define BHQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/bhq_pkg.sv]
// Types and constants shared by the button hold qualifier
`timescale 1ns / 1ps

package bhq_pkg;

    localparam int CNT_W  = 8;
    localparam int MSG_W  = 3;
    localparam int CFG_W  = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACKLIGHT_HOLD = 1'd1;

    localparam logic [MSG_W-1:0] MSG_NONE     = 3'd0;
    localparam logic [MSG_W-1:0] MSG_MUTE_ON  = 3'd1;
    localparam logic [MSG_W-1:0] MSG_MUTE_OFF = 3'd2;
    localparam logic [MSG_W-1:0] MSG_LOCKED   = 3'd3;
    localparam logic [MSG_W-1:0] MSG_UNLOCKED = 3'd4;

    localparam logic ACT_TICK      = 1'b0;
    localparam logic ACT_BACKLIGHT = 1'b1;

    typedef struct packed {
        logic action;
        logic star_down;
        logic up_down;
        logic num_down;
        logic down_key_down;
    } in_item_t;

    typedef struct packed {
        logic             star_long_press;
        logic             num_long_press;
        logic [MSG_W-1:0] message_code;
        logic             mute_on;
        logic             keys_locked;
        logic             backlight_lit;
        logic             backlight_expired;
    } out_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] long_hold_ticks;
        logic [CNT_W-1:0] backlight_hold_ticks;
    } cfg_t;

endpackage

[src/bhq_if.sv]
// Valid/ready channel interfaces for tick input and result output
`timescale 1ns / 1ps

interface bhq_in_if;
    logic valid;
    logic ready;
    logic action;
    logic star_down;
    logic up_down;
    logic num_down;
    logic down_key_down;

    modport source (output valid, action, star_down, up_down, num_down, down_key_down,
                    input ready);
    modport sink (input valid, action, star_down, up_down, num_down, down_key_down,
                  output ready);
endinterface

interface bhq_out_if;
    logic       valid;
    logic       ready;
    logic       star_long_press;
    logic       num_long_press;
    logic [2:0] message_code;
    logic       mute_on;
    logic       keys_locked;
    logic       backlight_lit;
    logic       backlight_expired;

    modport source (output valid, star_long_press, num_long_press, message_code, mute_on,
                    keys_locked, backlight_lit, backlight_expired,
                    input ready);
    modport sink (input valid, star_long_press, num_long_press, message_code, mute_on,
                  keys_locked, backlight_lit, backlight_expired,
                  output ready);
endinterface

[src/bhq_cfg_regs.sv]
// Configuration registers for the hold thresholds
`timescale 1ns / 1ps

module bhq_cfg_regs
    import bhq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LONG_HOLD:      cfg_next.long_hold_ticks      = cfg_data;
                REG_BACKLIGHT_HOLD: cfg_next.backlight_hold_ticks = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_hold_ticks      <= 8'd3;
            cfg_reg.backlight_hold_ticks <= 8'd3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/bhq_step.sv]
// Hold counters, flags and backlight timeout updated once per transaction
`timescale 1ns / 1ps

module bhq_step
    import bhq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic [CNT_W-1:0] mute_cnt_reg, mute_cnt_next;
    logic [CNT_W-1:0] lock_cnt_reg, lock_cnt_next;
    logic [CNT_W-1:0] star_cnt_reg, star_cnt_next;
    logic [CNT_W-1:0] num_cnt_reg,  num_cnt_next;
    logic [CNT_W-1:0] light_cnt_reg, light_cnt_next;
    logic             light_on_reg, light_on_next;
    logic             mute_reg, mute_next;
    logic             lock_reg, lock_next;

    logic [CNT_W-1:0] star_inc;
    logic [CNT_W-1:0] num_inc;

    assign star_inc = star_cnt_reg + 8'd1;
    assign num_inc  = num_cnt_reg + 8'd1;

    always_comb
    begin
        mute_cnt_next  = mute_cnt_reg;
        lock_cnt_next  = lock_cnt_reg;
        star_cnt_next  = star_cnt_reg;
        num_cnt_next   = num_cnt_reg;
        light_cnt_next = light_cnt_reg;
        light_on_next  = light_on_reg;
        mute_next      = mute_reg;
        lock_next      = lock_reg;
        result         = '0;
        result.message_code = MSG_NONE;

        if (item.action == ACT_BACKLIGHT)
        begin
            light_on_next  = 1'b1;
            light_cnt_next = '0;
        end
        else
        begin
            // backlight timeout first
            if (light_on_reg)
            begin
                if (light_cnt_reg > cfg.backlight_hold_ticks)
                begin
                    light_cnt_next = '0;
                    light_on_next  = 1'b0;
                    result.backlight_expired = 1'b1;
                end
                else
                begin
                    light_cnt_next = light_cnt_reg + 8'd1;
                end
            end

            if (item.star_down && item.up_down)
            begin
                if (mute_cnt_reg > cfg.long_hold_ticks)
                begin
                    mute_next     = !mute_reg;
                    mute_cnt_next = '0;
                    result.message_code = mute_reg ? MSG_MUTE_OFF : MSG_MUTE_ON;
                end
                else
                begin
                    mute_cnt_next = mute_cnt_reg + 8'd1;
                end
            end
            else if (item.num_down && item.down_key_down)
            begin
                if (lock_cnt_reg > cfg.long_hold_ticks)
                begin
                    lock_next     = !lock_reg;
                    lock_cnt_next = '0;
                    result.message_code = lock_reg ? MSG_UNLOCKED : MSG_LOCKED;
                end
                else
                begin
                    lock_cnt_next = lock_cnt_reg + 8'd1;
                end
            end
            else
            begin
                lock_cnt_next = '0;
                if (item.star_down)
                begin
                    if (star_inc > cfg.long_hold_ticks)
                    begin
                        result.star_long_press = 1'b1;
                        star_cnt_next = '0;
                    end
                    else
                    begin
                        star_cnt_next = star_inc;
                    end
                end
                else
                begin
                    star_cnt_next = '0;
                end
                if (item.num_down)
                begin
                    if (num_inc > cfg.long_hold_ticks)
                    begin
                        result.num_long_press = 1'b1;
                        num_cnt_next = '0;
                    end
                    else
                    begin
                        num_cnt_next = num_inc;
                    end
                end
                else
                begin
                    num_cnt_next = '0;
                end
            end
        end

        result.mute_on       = mute_next;
        result.keys_locked   = lock_next;
        result.backlight_lit = light_on_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mute_cnt_reg  <= '0;
            lock_cnt_reg  <= '0;
            star_cnt_reg  <= '0;
            num_cnt_reg   <= '0;
            light_cnt_reg <= '0;
            light_on_reg  <= 1'b0;
            mute_reg      <= 1'b0;
            lock_reg      <= 1'b0;
        end
        else if (accept)
        begin
            mute_cnt_reg  <= mute_cnt_next;
            lock_cnt_reg  <= lock_cnt_next;
            star_cnt_reg  <= star_cnt_next;
            num_cnt_reg   <= num_cnt_next;
            light_cnt_reg <= light_cnt_next;
            light_on_reg  <= light_on_next;
            mute_reg      <= mute_next;
            lock_reg      <= lock_next;
        end
    end

endmodule

[src/bhq_out_reg.sv]
// Result register holding one transaction until the sink takes it
`timescale 1ns / 1ps

module bhq_out_reg
    import bhq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_item_t data,
    input  logic      out_ready,
    output logic      out_valid,
    output out_item_t out_data
);

    logic      valid_reg, valid_next;
    out_item_t data_reg;

    assign valid_next = load | (valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[src/button_hold_qualifier.sv]
// Top level of the button hold qualifier
//
//  channel  | dir | handshake       | payload
//  tick     | in  | valid / ready   | action, star_down, up_down, num_down, down_key_down
//  result   | out | valid / ready   | pulses, message_code, flags, backlight status
//  cfg      | in  | cfg_we          | cfg_index, cfg_data
//
// One transaction per cycle while the result sink keeps up; its result appears in the cycle after acceptance.
// The hold counters and flags update at the accepting edge; a result register follows.
// tick.ready is high while the result register is empty or being drained this cycle.
// A stalled result sink holds the result register and with it further transactions.
// Reset clears all counters and flags and sets both thresholds to 3.
`timescale 1ns / 1ps
`include "button_hold_qualifier_defines.svh"

module button_hold_qualifier
    import bhq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    bhq_in_if.sink               tick,
    bhq_out_if.source            result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t      cfg;
    in_item_t  item;
    out_item_t step_result;
    out_item_t held;
    logic      accept;
    logic      out_valid;

    assign item.action        = tick.action;
    assign item.star_down     = tick.star_down;
    assign item.up_down       = tick.up_down;
    assign item.num_down      = tick.num_down;
    assign item.down_key_down = tick.down_key_down;

    assign tick.ready = ~out_valid | result.ready;
    assign accept     = tick.valid & tick.ready;

    bhq_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bhq_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg),
        .result (step_result)
    );

    bhq_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .data      (step_result),
        .out_ready (result.ready),
        .out_valid (out_valid),
        .out_data  (held)
    );

    assign result.valid             = out_valid;
    assign result.star_long_press   = held.star_long_press;
    assign result.num_long_press    = held.num_long_press;
    assign result.message_code      = held.message_code;
    assign result.mute_on           = held.mute_on;
    assign result.keys_locked       = held.keys_locked;
    assign result.backlight_lit     = held.backlight_lit;
    assign result.backlight_expired = held.backlight_expired;

    `BHQ_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, result.valid)
    `BHQ_ASSERT_NEXT(a_backlight_event_lights, clk, rst_n,
        accept && (tick.action == ACT_BACKLIGHT),
        result.backlight_lit && !result.backlight_expired && (result.message_code == MSG_NONE))
    `BHQ_ASSERT_SAME(a_expired_means_dark, clk, rst_n,
        result.valid && result.backlight_expired, !result.backlight_lit)

endmodule
